// ----- src/hrhs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhs_pkg
// shared types and character constants for the http response header stripper
// ----------------------------------------------------------------------------
package hrhs_pkg;

  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  // "HTTP" and "200"
  localparam logic [7:0] ProtoChar0 = 8'h48;
  localparam logic [7:0] ProtoChar1 = 8'h54;
  localparam logic [7:0] ProtoChar2 = 8'h54;
  localparam logic [7:0] ProtoChar3 = 8'h50;
  localparam logic [7:0] OkChar0    = 8'h32;
  localparam logic [7:0] OkChar1    = 8'h30;
  localparam logic [7:0] OkChar2    = 8'h30;

  // one-hot phase codes
  typedef enum logic [7:0] {
    PhStatus  = 8'b0000_0001,
    PhNeck1   = 8'b0000_0010,
    PhNeck2   = 8'b0000_0100,
    PhNeck3   = 8'b0000_1000,
    PhNeck4   = 8'b0001_0000,
    PhBody    = 8'b0010_0000,
    PhErr     = 8'b0100_0000,
    PhErrDone = 8'b1000_0000
  } phase_e;

  // streaming matcher state for the current status line
  typedef struct packed {
    logic [1:0] proto_prog;
    logic       proto_seen;
    logic [1:0] ok_prog;
    logic       ok_seen;
  } scan_t;

  // what the scanner reports about a byte
  typedef struct packed {
    logic line_end;
    logic line_proto;
    logic line_ok;
  } scan_verdict_t;

  // one result beat
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       header_done;
    logic       failed;
  } result_t;

  function automatic logic [7:0] proto_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = ProtoChar0;
      2'd1:    c = ProtoChar1;
      2'd2:    c = ProtoChar2;
      default: c = ProtoChar3;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ok_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd1:    c = OkChar1;
      2'd2:    c = OkChar2;
      default: c = OkChar0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hrhs_status_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhs_status_scan
// substring matchers for "HTTP" and "200" over one status line
// ----------------------------------------------------------------------------
module hrhs_status_scan (
  input  logic [7:0]             byte_i,
  input  hrhs_pkg::scan_t        scan_i,
  output hrhs_pkg::scan_t        scan_o,
  output hrhs_pkg::scan_verdict_t verdict_o
);
  import hrhs_pkg::*;

  scan_t      upd;
  logic [1:0] ok_idx;

  assign ok_idx = (scan_i.ok_prog == 2'd3) ? 2'd0 : scan_i.ok_prog;

  always_comb begin
    upd = scan_i;
    if (byte_i == proto_char(scan_i.proto_prog)) begin
      if (scan_i.proto_prog == 2'd3) begin
        upd.proto_seen = 1'b1;
        upd.proto_prog = 2'd0;
      end else begin
        upd.proto_prog = scan_i.proto_prog + 2'd1;
      end
    end else begin
      upd.proto_prog = (byte_i == ProtoChar0) ? 2'd1 : 2'd0;
    end

    if (byte_i == ok_char(ok_idx)) begin
      if (ok_idx == 2'd2) begin
        upd.ok_seen = 1'b1;
        upd.ok_prog = 2'd0;
      end else begin
        upd.ok_prog = ok_idx + 2'd1;
      end
    end else begin
      upd.ok_prog = (byte_i == OkChar0) ? 2'd1 : 2'd0;
    end
  end

  assign verdict_o.line_end   = (byte_i == CharLf);
  assign verdict_o.line_proto = upd.proto_seen;
  assign verdict_o.line_ok    = upd.ok_seen;
  // matchers restart on every new line
  assign scan_o = verdict_o.line_end ? '0 : upd;

endmodule

// ----- src/hrhs_phase_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhs_phase_fsm
// header phase tracking, blank-line hunt and body/error decisions
// ----------------------------------------------------------------------------
module hrhs_phase_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              abort_i,
  output hrhs_pkg::result_t result_o
);
  import hrhs_pkg::*;

  phase_e        phase_q, phase_d;
  scan_t         scan_q, scan_d, scan_next;
  scan_verdict_t verdict;
  logic          body_valid;

  hrhs_status_scan u_scan (
    .byte_i    (byte_i),
    .scan_i    (scan_q),
    .scan_o    (scan_next),
    .verdict_o (verdict)
  );

  always_comb begin
    phase_d    = phase_q;
    scan_d     = scan_q;
    body_valid = 1'b0;
    if (abort_i) begin
      phase_d = (phase_q == PhBody || phase_q == PhErrDone) ? PhErrDone : PhErr;
      scan_d  = '0;
    end else begin
      unique case (phase_q) inside
        PhStatus: begin
          scan_d = scan_next;
          if (verdict.line_end && verdict.line_proto) begin
            phase_d = verdict.line_ok ? PhNeck1 : PhErr;
          end
        end
        PhNeck1: begin
          if (byte_i == CharCr) phase_d = PhNeck2;
        end
        PhNeck2: begin
          if (byte_i == CharLf)      phase_d = PhNeck3;
          else if (byte_i != CharCr) phase_d = PhNeck1;
        end
        PhNeck3: begin
          phase_d = (byte_i == CharCr) ? PhNeck4 : PhNeck1;
        end
        PhNeck4: begin
          if (byte_i == CharLf)      phase_d = PhBody;
          else if (byte_i == CharCr) phase_d = PhNeck2;
          else                       phase_d = PhNeck1;
        end
        PhBody: begin
          body_valid = 1'b1;
        end
        PhErr, PhErrDone: begin
          phase_d = phase_q;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  assign result_o.body_byte   = body_valid ? byte_i : 8'h00;
  assign result_o.body_valid  = body_valid;
  assign result_o.header_done = (phase_d == PhBody) || (phase_d == PhErrDone);
  assign result_o.failed      = (phase_d == PhErr) || (phase_d == PhErrDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStatus;
      scan_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      scan_q  <= scan_d;
    end
  end

endmodule

// ----- src/http_response_header_stripper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_stripper_top
// strips the status line and headers of an http reply and passes the body
// ----------------------------------------------------------------------------
// pipeline: input register, then result register; throughput: one byte per
//   cycle while out_ready_i keeps the result register draining, set by the
//   combinational phase update between the two registers
// reset: rst_ni async active low; clears both valid flags, the phase (back to
//   awaiting the status line) and the line matchers
// ----------------------------------------------------------------------------
module http_response_header_stripper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       abort_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] body_byte_o,
  output logic       body_valid_o,
  output logic       header_done_o,
  output logic       failed_o
);
  import hrhs_pkg::*;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_abort_q;

  // result stage
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    step_result;

  logic in_fire;
  logic out_adv;   // result register free or being drained this cycle
  logic step_fire; // input stage beat moves into the result register

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_adv   = !out_valid_q || out_ready_i;
  assign step_fire = s1_valid_q && out_adv;
  // input register refills as soon as its beat moves on
  assign in_ready_o = !s1_valid_q || out_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)        s1_valid_d = 1'b1;
    else if (step_fire) s1_valid_d = 1'b0;
  end

  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  // phase state advances only when a beat actually reaches the result register
  hrhs_phase_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step_fire),
    .byte_i   (s1_byte_q),
    .abort_i  (s1_abort_q),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= data_byte_i;
      s1_abort_q <= abort_i;
    end
    if (step_fire) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign body_byte_o   = out_q.body_byte;
  assign body_valid_o  = out_q.body_valid;
  assign header_done_o = out_q.header_done;
  assign failed_o      = out_q.failed;

endmodule

// ----- src/hrhs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhs_checker
// port-level checks for the http response header stripper
// ----------------------------------------------------------------------------
module hrhs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] body_byte_o,
  input logic       body_valid_o,
  input logic       header_done_o,
  input logic       failed_o
);

  logic failed_seen_q;
  logic done_seen_q;
  logic out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_seen_q <= 1'b0;
      done_seen_q   <= 1'b0;
    end else if (out_fire) begin
      failed_seen_q <= failed_seen_q || failed_o;
      done_seen_q   <= done_seen_q || header_done_o;
    end
  end

  // body only flows after the header and outside the error state
  a_body_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && body_valid_o |-> header_done_o && !failed_o)
    else $error("body beat before header end or in error");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !body_valid_o |-> body_byte_o == 8'h00)
    else $error("non-body beat carries a byte");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && failed_seen_q |-> failed_o)
    else $error("failed flag dropped");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_seen_q |-> header_done_o)
    else $error("header_done flag dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(body_byte_o))
    else $error("result beat changed while stalled");

endmodule

bind http_response_header_stripper_top hrhs_checker u_hrhs_checker (.*);
